[rtl/assert_macros.svh]
// Assertion macros shared by the deframer checker.
// Depends on nothing; the user must have clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is asserted.
`define STFD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked check that also holds during reset.
`define STFD_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/stfd_pkg.sv]
// Shared types, codes and widths for the sync/trailer frame deframer.
// Depends on nothing; used by the core, the frame RAM and the checker.
`default_nettype none

package stfd_pkg;

    localparam int FRAME_BYTES_DEF = 78;

    localparam int CMD_W      = 1;
    localparam int BYTE_W     = 8;
    localparam int IDX_W      = 7;
    localparam int STATUS_W   = 3;
    localparam int FILL_W     = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 16;

    localparam logic [BYTE_W-1:0] START_FIRST_RST  = 8'h48;
    localparam logic [BYTE_W-1:0] START_SECOND_RST = 8'h4B;
    localparam logic [BYTE_W-1:0] END_FIRST_RST    = 8'h4B;
    localparam logic [BYTE_W-1:0] END_SECOND_RST   = 8'h48;

    typedef enum logic [STATUS_W-1:0] {
        STAT_HUNT    = 3'd0,
        STAT_COLLECT = 3'd1,
        STAT_GOOD    = 3'd2,
        STAT_RESYNC  = 3'd3,
        STAT_DROP    = 3'd4,
        STAT_READ    = 3'd5
    } status_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH = 1'b0,
        CMD_READ = 1'b1
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_FIRST  = 2'd0,
        CFG_START_SECOND = 2'd1,
        CFG_END_FIRST    = 2'd2,
        CFG_END_SECOND   = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        FSM_IDLE  = 3'd0,
        FSM_READ  = 3'd1,
        FSM_SCAN  = 3'd2,
        FSM_SHIFT = 3'd3,
        FSM_EMIT  = 3'd4
    } fsm_t;

endpackage

`default_nettype wire

[rtl/stfd_ram.sv]
// Generic single-clock RAM: one write port, one read port, registered read.
// Depends on stfd_pkg for default sizes only.
`default_nettype none

module stfd_ram #(
    parameter int WIDTH = stfd_pkg::BYTE_W,
    parameter int DEPTH = stfd_pkg::FRAME_BYTES_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[rtl/sync_trailer_frame_deframer_core.sv]
// Top level of the sync/trailer frame deframer: hunt, collect, trailer check, resync.
// Depends on stfd_pkg and stfd_ram (frame store).
//
//  channel   | dir | handshake                    | payload
//  ----------+-----+------------------------------+-------------------------------------
//  s_axis    | in  | s_axis_tvalid/s_axis_tready  | tuser: command; tdata: rx_byte, index
//  m_axis    | out | m_axis_tvalid/m_axis_tready  | tuser: status; tdata: fill, read_data
//  cfg       | in  | cfg_valid/cfg_ready          | cfg_index, cfg_data (mark registers)
//
// A push that leaves the store short of full goes through EMIT to the output
// register once it is free; a read goes through READ and EMIT. A push that fills the
// store runs a scan of FRAME_BYTES-1 RAM reads, then for a resync a copy of
// FRAME_BYTES-i bytes, all through the single read port of the frame RAM. One item is
// worked on at a time; the result register lets the next beat in while the previous
// result waits on m_axis_tready.
// Reset (rst_n low, asynchronous) empties the store and restores the marks.
`default_nettype none

module sync_trailer_frame_deframer_core #(
    parameter int FRAME_BYTES = stfd_pkg::FRAME_BYTES_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // slave side
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // [7:0] rx_byte, [14:8] read_index, [15] zero
    input  wire logic [stfd_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // [0] command
    input  wire logic                             s_axis_tuser,
    // master side
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // [6:0] fill_level, [14:7] read_data, [15] zero
    output logic      [stfd_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    // [2:0] status
    output logic      [stfd_pkg::STATUS_W-1:0]    m_axis_tuser,
    // configuration write channel
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [stfd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [stfd_pkg::BYTE_W-1:0]      cfg_data
);

    import stfd_pkg::*;

    localparam int AW = $clog2(FRAME_BYTES);
    localparam int CW = $clog2(FRAME_BYTES + 1);
    localparam logic [CW-1:0] FULL = CW'(FRAME_BYTES);
    localparam logic [CW-1:0] LAST = CW'(FRAME_BYTES - 1);

    // mark registers
    logic [BYTE_W-1:0] start_first_reg, start_second_reg;
    logic [BYTE_W-1:0] end_first_reg, end_second_reg;

    // control state
    fsm_t             fsm_reg, fsm_next;
    logic [CW-1:0]    fill_reg, fill_next;
    logic [CW-1:0]    rd_addr_reg, rd_addr_next;
    logic [AW-1:0]    wr_addr_reg, wr_addr_next;
    logic             rdv_reg, rdv_next;
    logic [CW-1:0]    addr_d_reg, addr_d_next;
    logic [BYTE_W-1:0] prev_reg, prev_next;
    logic             found_reg, found_next;
    logic [CW-1:0]    pos_reg, pos_next;
    logic             rd_ok_reg, rd_ok_next;

    // pending result
    status_t          res_status_reg, res_status_next;
    logic [CW-1:0]    res_fill_reg, res_fill_next;
    logic [BYTE_W-1:0] res_data_reg, res_data_next;

    // output register
    logic             out_valid_reg, out_valid_next;
    status_t          out_status_reg;
    logic [FILL_W-1:0] out_fill_reg;
    logic [BYTE_W-1:0] out_data_reg;
    logic             out_load;

    // frame RAM port signals
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [BYTE_W-1:0] ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [BYTE_W-1:0] ram_rdata;

    // unpacked input beat
    cmd_t              in_cmd;
    logic [BYTE_W-1:0] in_byte;
    logic [IDX_W-1:0]  in_idx;
    logic              in_range;
    logic              in_accept;

    // scan helpers
    logic              issue;
    logic              pair_hit;
    logic              trailer_ok;
    logic              out_free;

    assign in_cmd    = cmd_t'(s_axis_tuser);
    assign in_byte   = s_axis_tdata[BYTE_W-1:0];
    assign in_idx    = s_axis_tdata[BYTE_W +: IDX_W];
    assign in_range  = (32'(in_idx) < FRAME_BYTES);

    assign s_axis_tready = (fsm_reg == FSM_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;

    assign issue      = (rd_addr_reg < FULL);
    assign pair_hit   = (addr_d_reg >= CW'(2)) && (prev_reg == start_first_reg)
                        && (ram_rdata == start_second_reg);
    assign trailer_ok = (prev_reg == end_first_reg) && (ram_rdata == end_second_reg);

    stfd_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (FRAME_BYTES)
    ) u_frame_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Sequencer: next state, RAM strobes and result
    always_comb
    begin
        fsm_next        = fsm_reg;
        fill_next       = fill_reg;
        rd_addr_next    = rd_addr_reg;
        wr_addr_next    = wr_addr_reg;
        rdv_next        = 1'b0;
        addr_d_next     = addr_d_reg;
        prev_next       = prev_reg;
        found_next      = found_reg;
        pos_next        = pos_reg;
        rd_ok_next      = rd_ok_reg;
        res_status_next = res_status_reg;
        res_fill_next   = res_fill_reg;
        res_data_next   = res_data_reg;
        out_load        = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = fill_reg[AW-1:0];
        ram_wdata       = in_byte;
        ram_re          = 1'b0;
        ram_raddr       = rd_addr_reg[AW-1:0];

        case (fsm_reg)
            FSM_IDLE:
            begin
                if (in_accept)
                begin
                    res_data_next = '0;
                    if (in_cmd == CMD_READ)
                    begin
                        // fetch the entry; out-of-range answers zero
                        ram_re     = in_range;
                        ram_raddr  = AW'(in_idx);
                        rd_ok_next = in_range;
                        fsm_next   = FSM_READ;
                    end
                    else if (fill_reg == '0)
                    begin
                        // hunt for the first mark
                        ram_waddr = '0;
                        if (in_byte == start_first_reg)
                        begin
                            ram_we    = 1'b1;
                            fill_next = CW'(1);
                        end
                        res_status_next = (in_byte == start_first_reg) ? STAT_COLLECT
                                                                       : STAT_HUNT;
                        res_fill_next   = (in_byte == start_first_reg) ? CW'(1) : '0;
                        fsm_next        = FSM_EMIT;
                    end
                    else if (fill_reg == CW'(1))
                    begin
                        if (in_byte == start_second_reg)
                        begin
                            ram_we          = 1'b1;
                            ram_waddr       = AW'(1);
                            fill_next       = CW'(2);
                            res_status_next = STAT_COLLECT;
                            res_fill_next   = CW'(2);
                        end
                        else if (in_byte == start_first_reg)
                        begin
                            // keep this byte as a fresh first mark
                            ram_we          = 1'b1;
                            ram_waddr       = '0;
                            res_status_next = STAT_COLLECT;
                            res_fill_next   = CW'(1);
                        end
                        else
                        begin
                            fill_next       = '0;
                            res_status_next = STAT_HUNT;
                            res_fill_next   = '0;
                        end
                        fsm_next = FSM_EMIT;
                    end
                    else
                    begin
                        // append to the frame
                        ram_we    = 1'b1;
                        fill_next = fill_reg + CW'(1);
                        if (fill_reg == LAST)
                        begin
                            rd_addr_next = CW'(1);
                            found_next   = 1'b0;
                            fsm_next     = FSM_SCAN;
                        end
                        else
                        begin
                            res_status_next = STAT_COLLECT;
                            res_fill_next   = fill_reg + CW'(1);
                            fsm_next        = FSM_EMIT;
                        end
                    end
                end
            end

            FSM_READ:
            begin
                res_status_next = STAT_READ;
                res_fill_next   = fill_reg;
                res_data_next   = rd_ok_reg ? ram_rdata : '0;
                fsm_next        = FSM_EMIT;
            end

            FSM_SCAN:
            begin
                // stream the store from position 1; look for pairs and the trailer
                ram_re       = issue;
                rdv_next     = issue;
                addr_d_next  = rd_addr_reg;
                if (issue)
                begin
                    rd_addr_next = rd_addr_reg + CW'(1);
                end
                if (rdv_reg)
                begin
                    prev_next = ram_rdata;
                    if (!found_reg && pair_hit)
                    begin
                        found_next = 1'b1;
                        pos_next   = addr_d_reg - CW'(1);
                    end
                    if (addr_d_reg == LAST)
                    begin
                        if (trailer_ok)
                        begin
                            fill_next       = '0;
                            res_status_next = STAT_GOOD;
                            res_fill_next   = '0;
                            fsm_next        = FSM_EMIT;
                        end
                        else if (found_reg || pair_hit)
                        begin
                            // move the tail that starts at the pair to the front
                            fill_next       = FULL - (found_reg ? pos_reg
                                                                : addr_d_reg - CW'(1));
                            res_status_next = STAT_RESYNC;
                            res_fill_next   = FULL - (found_reg ? pos_reg
                                                                : addr_d_reg - CW'(1));
                            rd_addr_next    = found_reg ? pos_reg : addr_d_reg - CW'(1);
                            wr_addr_next    = '0;
                            fsm_next        = FSM_SHIFT;
                        end
                        else
                        begin
                            fill_next       = '0;
                            res_status_next = STAT_DROP;
                            res_fill_next   = '0;
                            fsm_next        = FSM_EMIT;
                        end
                    end
                end
            end

            FSM_SHIFT:
            begin
                // reads run at least one entry ahead of writes, so no overlap
                ram_re      = issue;
                rdv_next    = issue;
                addr_d_next = rd_addr_reg;
                if (issue)
                begin
                    rd_addr_next = rd_addr_reg + CW'(1);
                end
                if (rdv_reg)
                begin
                    ram_we       = 1'b1;
                    ram_waddr    = wr_addr_reg;
                    ram_wdata    = ram_rdata;
                    wr_addr_next = wr_addr_reg + AW'(1);
                    if (addr_d_reg == LAST)
                    begin
                        fsm_next = FSM_EMIT;
                    end
                end
            end

            FSM_EMIT:
            begin
                // hold until the output register is free
                if (out_free)
                begin
                    out_load = 1'b1;
                    fsm_next = FSM_IDLE;
                end
            end

            default:
            begin
                fsm_next = FSM_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg       <= FSM_IDLE;
            fill_reg      <= '0;
            rdv_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fsm_reg       <= fsm_next;
            fill_reg      <= fill_next;
            rdv_reg       <= rdv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // working and payload registers
    always_ff @(posedge clk)
    begin
        rd_addr_reg    <= rd_addr_next;
        wr_addr_reg    <= wr_addr_next;
        addr_d_reg     <= addr_d_next;
        prev_reg       <= prev_next;
        found_reg      <= found_next;
        pos_reg        <= pos_next;
        rd_ok_reg      <= rd_ok_next;
        res_status_reg <= res_status_next;
        res_fill_reg   <= res_fill_next;
        res_data_reg   <= res_data_next;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_fill_reg   <= FILL_W'(res_fill_reg);
            out_data_reg   <= res_data_reg;
        end
    end

    // mark registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_first_reg  <= START_FIRST_RST;
            start_second_reg <= START_SECOND_RST;
            end_first_reg    <= END_FIRST_RST;
            end_second_reg   <= END_SECOND_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_START_FIRST:  start_first_reg  <= cfg_data;
                CFG_START_SECOND: start_second_reg <= cfg_data;
                CFG_END_FIRST:    end_first_reg    <= cfg_data;
                CFG_END_SECOND:   end_second_reg   <= cfg_data;
                default:          start_first_reg  <= start_first_reg;
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {1'b0, out_data_reg, out_fill_reg};

endmodule

`default_nettype wire

[rtl/stfd_checker.sv]
// Port-level checker for the deframer core, attached by bind.
// Depends on stfd_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module stfd_checker (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             s_axis_tvalid,
    input wire logic                             s_axis_tready,
    input wire logic                             m_axis_tvalid,
    input wire logic                             m_axis_tready,
    input wire logic [stfd_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    input wire logic [stfd_pkg::STATUS_W-1:0]    m_axis_tuser
);

    import stfd_pkg::*;

    logic              rd_reply;
    logic [BYTE_W-1:0] out_rdata;

    assign rd_reply  = (m_axis_tuser == STAT_READ);
    assign out_rdata = m_axis_tdata[FILL_W +: BYTE_W];

    // in the cycle after reset is seen low no result beat may be shown
    `STFD_ASSERT_RST(a_no_beat_in_reset, (!rst_n |=> !m_axis_tvalid), "beat in reset")

    // a result beat stays until taken
    `STFD_ASSERT(a_out_hold, (m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid), "beat lost")

    // one item at a time: ready falls after each accepted beat
    `STFD_ASSERT(a_one_item, (s_axis_tvalid && s_axis_tready |=> !s_axis_tready), "overlapped")

    // read data is zero unless the beat is a read reply
    `STFD_ASSERT(a_data_zero, (m_axis_tvalid && !rd_reply |-> out_rdata == '0), "stray data")

endmodule

bind sync_trailer_frame_deframer_core stfd_checker u_stfd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
